[rtl/session_mode_controller_defines.svh]
// Assertion macros shared by the session mode controller RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef SESSION_MODE_CONTROLLER_DEFINES_SVH
`define SESSION_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SMC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smc check failed");

// Next-cycle implication, disabled during reset
`define SMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smc check failed");

`endif

[rtl/smc_pkg.sv]
// Types and constants for the session mode controller.
// No dependencies; used by smc_step and session_mode_controller.
package smc_pkg;

  // Word kinds
  localparam logic [3:0] KIND_TICK        = 4'd0;
  localparam logic [3:0] KIND_START       = 4'd1;
  localparam logic [3:0] KIND_END         = 4'd2;
  localparam logic [3:0] KIND_SANCTUARY   = 4'd3;
  localparam logic [3:0] KIND_PRIME       = 4'd4;
  localparam logic [3:0] KIND_ROUND_START = 4'd5;
  localparam logic [3:0] KIND_ROUND_END   = 4'd6;
  localparam logic [3:0] KIND_TALLY       = 4'd7;
  localparam logic [3:0] KIND_RESTORE     = 4'd8;

  // Modes
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_SANCTUARY = 3'd1;
  localparam logic [2:0] MODE_TRANQUIL  = 3'd2;
  localparam logic [2:0] MODE_PRIME     = 3'd3;
  localparam logic [2:0] MODE_SUSTAIN   = 3'd4;
  localparam logic [2:0] MODE_RECOVER   = 3'd5;

  // Cues
  localparam logic [2:0] CUE_NONE    = 3'd0;
  localparam logic [2:0] CUE_MODE    = 3'd1;
  localparam logic [2:0] CUE_SUMMARY = 3'd2;
  localparam logic [2:0] CUE_TALLY   = 3'd3;
  localparam logic [2:0] CUE_IMPACT  = 3'd4;

  // Pacer patterns
  localparam logic [1:0] PACER_OFF       = 2'd0;
  localparam logic [1:0] PACER_RESONANCE = 2'd1;
  localparam logic [1:0] PACER_PRIME     = 2'd2;
  localparam logic [1:0] PACER_SIGH      = 2'd3;

  // Pacer phase durations in ms
  localparam logic [11:0] CALM_FIRST_MS    = 12'd4000;
  localparam logic [12:0] CALM_SECOND_MS   = 13'd6000;
  localparam logic [11:0] PRIME_FIRST_MS   = 12'd2000;
  localparam logic [12:0] PRIME_SECOND_MS  = 13'd1000;
  localparam logic [11:0] RECOV_FIRST_MS   = 12'd3000;
  localparam logic [12:0] RECOV_SECOND_MS  = 13'd7000;

  // Register map (index = byte address / 4)
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_PRIME_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_RECOVER_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RECOVERED_MARGIN = 2'd2;
  localparam logic [1:0] REG_IMPACT_THRESHOLD = 2'd3;

  // Register reset values
  localparam logic [31:0] PRIME_TIMEOUT_RST   = 32'd60000;
  localparam logic [31:0] RECOVER_TIMEOUT_RST = 32'd120000;
  localparam logic [11:0] RECOVERED_MARGIN_RST = 12'd160;
  localparam logic [11:0] IMPACT_THRESHOLD_RST = 12'd128;

  typedef struct packed {
    logic [3:0]        kind;
    logic [31:0]       time_ms;
    logic [11:0]       hr_value;
    logic              hr_valid;
    logic signed [1:0] still_flag;
    logic [11:0]       impact_value;
    logic              impact_valid;
    logic [31:0]       restore_tally;
  } item_t;

  typedef struct packed {
    logic        in_session;
    logic [2:0]  mode;
    logic [31:0] entered_time;
    logic [31:0] tally;
    logic [11:0] resting_rate;
    logic        resting_known;
  } state_t;

  typedef struct packed {
    logic [31:0] prime_timeout_ms;
    logic [31:0] recover_timeout_ms;
    logic [11:0] recovered_margin;
    logic [11:0] impact_threshold;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cue_type;
    logic [2:0]  current_mode;
    logic [31:0] tally_count;
    logic [8:0]  impact_rounded;
    logic        pacer_enabled;
    logic [11:0] pacer_first_ms;
    logic [12:0] pacer_second_ms;
    logic [1:0]  pacer_pattern;
  } result_t;

  // Round a 1/16 g reading to whole g, ties to even
  function automatic logic [8:0] round_g(input logic [11:0] v);
    logic [8:0] q;
    logic [3:0] r;
    q = {1'b0, v[11:4]};
    r = v[3:0];
    if (r > 4'd8 || (r == 4'd8 && q[0])) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

endpackage

[rtl/smc_step.sv]
// Next-state and result logic for one word of the session mode controller.
// Depends on smc_pkg; instantiated by session_mode_controller.
module smc_step (
  input  smc_pkg::item_t   item,
  input  smc_pkg::state_t  state,
  input  smc_pkg::cfg_t    cfg,
  output smc_pkg::state_t  state_next,
  output smc_pkg::result_t result
);

  logic [31:0] elapsed;
  logic [12:0] recov_limit;
  logic        still;
  logic        calm;
  logic        prime_done;
  logic        recov_done;
  logic        impact_hit;
  logic [2:0]  cue;
  logic [8:0]  imp_r;
  logic [2:0]  target;
  logic        do_go;

  // Shared terms for ticks
  assign elapsed     = item.time_ms - state.entered_time;
  assign recov_limit = {1'b0, state.resting_rate} + {1'b0, cfg.recovered_margin};
  assign still       = (item.still_flag == 2'sb01);
  assign calm        = (state.mode == smc_pkg::MODE_TRANQUIL) ||
                       (state.mode == smc_pkg::MODE_SANCTUARY);
  assign prime_done  = (state.mode == smc_pkg::MODE_PRIME) &&
                       (elapsed >= cfg.prime_timeout_ms);
  assign recov_done  = (state.mode == smc_pkg::MODE_RECOVER) &&
                       ((state.resting_known && item.hr_valid &&
                         ({1'b0, item.hr_value} <= recov_limit)) ||
                        (elapsed >= cfg.recover_timeout_ms));
  assign impact_hit  = (state.mode == smc_pkg::MODE_SUSTAIN) && item.impact_valid &&
                       (item.impact_value >= cfg.impact_threshold);

  // Decode the word into a state update and a cue
  always_comb begin
    state_next = state;
    cue        = smc_pkg::CUE_NONE;
    imp_r      = '0;
    target     = state.mode;
    do_go      = 1'b0;
    case (item.kind)
      smc_pkg::KIND_START: begin
        state_next.in_session = 1'b1;
        target = smc_pkg::MODE_TRANQUIL;
        do_go  = 1'b1;
      end
      smc_pkg::KIND_END: begin
        state_next.in_session   = 1'b0;
        state_next.mode         = smc_pkg::MODE_NONE;
        state_next.entered_time = '0;
        cue = smc_pkg::CUE_SUMMARY;
      end
      smc_pkg::KIND_RESTORE: begin
        // Always a fresh entry to tranquil
        state_next.in_session   = 1'b1;
        state_next.tally        = item.restore_tally;
        state_next.mode         = smc_pkg::MODE_TRANQUIL;
        state_next.entered_time = item.time_ms;
        cue = smc_pkg::CUE_MODE;
      end
      smc_pkg::KIND_TICK: begin
        if (state.in_session && state.mode != smc_pkg::MODE_NONE) begin
          // Track the lowest still heart rate in calm modes
          if (calm && item.hr_valid && still) begin
            if (!state.resting_known || item.hr_value < state.resting_rate) begin
              state_next.resting_rate = item.hr_value;
            end
            state_next.resting_known = 1'b1;
          end
          if (prime_done || recov_done) begin
            target = smc_pkg::MODE_TRANQUIL;
            do_go  = 1'b1;
          end
          if (impact_hit) begin
            cue   = smc_pkg::CUE_IMPACT;
            imp_r = smc_pkg::round_g(item.impact_value);
          end
        end
      end
      smc_pkg::KIND_SANCTUARY: begin
        target = smc_pkg::MODE_SANCTUARY;
        do_go  = state.in_session;
      end
      smc_pkg::KIND_PRIME: begin
        target = smc_pkg::MODE_PRIME;
        do_go  = state.in_session;
      end
      smc_pkg::KIND_ROUND_START: begin
        target = smc_pkg::MODE_SUSTAIN;
        do_go  = state.in_session;
      end
      smc_pkg::KIND_ROUND_END: begin
        target = smc_pkg::MODE_RECOVER;
        do_go  = state.in_session;
      end
      smc_pkg::KIND_TALLY: begin
        if (state.in_session) begin
          state_next.tally = state.tally + 32'd1;
          cue = smc_pkg::CUE_TALLY;
        end
      end
      default: begin
      end
    endcase
    // Enter a new mode; re-entering the current one is silent
    if (do_go && target != state.mode) begin
      state_next.mode         = target;
      state_next.entered_time = item.time_ms;
      cue = smc_pkg::CUE_MODE;
    end
  end

  // Report with pacer settings of the resulting mode
  always_comb begin
    result.cue_type        = cue;
    result.current_mode    = state_next.mode;
    result.tally_count     = state_next.tally;
    result.impact_rounded  = imp_r;
    result.pacer_enabled   = 1'b0;
    result.pacer_first_ms  = '0;
    result.pacer_second_ms = '0;
    result.pacer_pattern   = smc_pkg::PACER_OFF;
    case (state_next.mode)
      smc_pkg::MODE_SANCTUARY, smc_pkg::MODE_TRANQUIL: begin
        result.pacer_enabled   = 1'b1;
        result.pacer_first_ms  = smc_pkg::CALM_FIRST_MS;
        result.pacer_second_ms = smc_pkg::CALM_SECOND_MS;
        result.pacer_pattern   = smc_pkg::PACER_RESONANCE;
      end
      smc_pkg::MODE_PRIME: begin
        result.pacer_enabled   = 1'b1;
        result.pacer_first_ms  = smc_pkg::PRIME_FIRST_MS;
        result.pacer_second_ms = smc_pkg::PRIME_SECOND_MS;
        result.pacer_pattern   = smc_pkg::PACER_PRIME;
      end
      smc_pkg::MODE_RECOVER: begin
        result.pacer_enabled   = 1'b1;
        result.pacer_first_ms  = smc_pkg::RECOV_FIRST_MS;
        result.pacer_second_ms = smc_pkg::RECOV_SECOND_MS;
        result.pacer_pattern   = smc_pkg::PACER_SIGH;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/session_mode_controller.sv]
// Top level of the session mode controller: input stage, state, result stage, APB registers.
// Depends on smc_pkg, smc_step and session_mode_controller_defines.svh.
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_ready  kind .. restore_tally
//   result    out        out_valid/out_ready cue_type .. pacer_pattern
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// One word per cycle sustained while results are taken; a word is registered in the input
// stage and then in the result register before it leaves.
// The input register feeds smc_step, whose output lands in the result register
// and the session state at the same edge, so the next word sees the update.
// A stalled result holds the input stage; one more word is taken and waits there.
// rst is synchronous: both stages empty, state cleared, registers at defaults.
`include "session_mode_controller_defines.svh"

module session_mode_controller (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  kind,
  input  logic [31:0]                 time_ms,
  input  logic [11:0]                 hr_value,
  input  logic                        hr_valid,
  input  logic signed [1:0]           still_flag,
  input  logic [11:0]                 impact_value,
  input  logic                        impact_valid,
  input  logic [31:0]                 restore_tally,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  cue_type,
  output logic [2:0]                  current_mode,
  output logic [31:0]                 tally_count,
  output logic [8:0]                  impact_rounded,
  output logic                        pacer_enabled,
  output logic [11:0]                 pacer_first_ms,
  output logic [12:0]                 pacer_second_ms,
  output logic [1:0]                  pacer_pattern,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  smc_pkg::item_t   in_word;
  smc_pkg::item_t   s1_item;
  logic             s1_valid;
  logic             advance;
  smc_pkg::state_t  state;
  smc_pkg::state_t  state_next;
  smc_pkg::cfg_t    cfg;
  smc_pkg::result_t step_res;
  smc_pkg::result_t res;
  logic             cfg_write;
  logic [1:0]       reg_index;

  // Gather the input word
  assign in_word.kind          = kind;
  assign in_word.time_ms       = time_ms;
  assign in_word.hr_value      = hr_value;
  assign in_word.hr_valid      = hr_valid;
  assign in_word.still_flag    = still_flag;
  assign in_word.impact_value  = impact_value;
  assign in_word.impact_valid  = impact_valid;
  assign in_word.restore_tally = restore_tally;

  // Advance the input stage whenever the result register can take a word
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_word;
    end
  end

  smc_step u_step (
    .item       (s1_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (step_res)
  );

  // Session state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign cue_type        = res.cue_type;
  assign current_mode    = res.current_mode;
  assign tally_count     = res.tally_count;
  assign impact_rounded  = res.impact_rounded;
  assign pacer_enabled   = res.pacer_enabled;
  assign pacer_first_ms  = res.pacer_first_ms;
  assign pacer_second_ms = res.pacer_second_ms;
  assign pacer_pattern   = res.pacer_pattern;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[smc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prime_timeout_ms   <= smc_pkg::PRIME_TIMEOUT_RST;
      cfg.recover_timeout_ms <= smc_pkg::RECOVER_TIMEOUT_RST;
      cfg.recovered_margin   <= smc_pkg::RECOVERED_MARGIN_RST;
      cfg.impact_threshold   <= smc_pkg::IMPACT_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (reg_index)
        smc_pkg::REG_PRIME_TIMEOUT:    cfg.prime_timeout_ms   <= pwdata;
        smc_pkg::REG_RECOVER_TIMEOUT:  cfg.recover_timeout_ms <= pwdata;
        smc_pkg::REG_RECOVERED_MARGIN: cfg.recovered_margin   <= pwdata[11:0];
        smc_pkg::REG_IMPACT_THRESHOLD: cfg.impact_threshold   <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_index)
      smc_pkg::REG_PRIME_TIMEOUT:    prdata = cfg.prime_timeout_ms;
      smc_pkg::REG_RECOVER_TIMEOUT:  prdata = cfg.recover_timeout_ms;
      smc_pkg::REG_RECOVERED_MARGIN: prdata = {20'd0, cfg.recovered_margin};
      smc_pkg::REG_IMPACT_THRESHOLD: prdata = {20'd0, cfg.impact_threshold};
      default:                       prdata = '0;
    endcase
  end

  // Checks
  `SMC_ASSERT_IMP(a_mode_none_out_of_session, clk, rst,
    !state.in_session, state.mode == smc_pkg::MODE_NONE)
  `SMC_ASSERT_IMP(a_impact_only_in_sustain, clk, rst,
    out_valid && cue_type == smc_pkg::CUE_IMPACT, current_mode == smc_pkg::MODE_SUSTAIN)
  `SMC_ASSERT_IMP(a_rounded_only_on_impact, clk, rst,
    out_valid && impact_rounded != 9'd0, cue_type == smc_pkg::CUE_IMPACT)
  `SMC_ASSERT_IMP(a_pacer_follows_mode, clk, rst,
    out_valid, pacer_enabled ==
    (current_mode != smc_pkg::MODE_NONE && current_mode != smc_pkg::MODE_SUSTAIN))
  `SMC_ASSERT_NEXT(a_stage_holds_on_stall, clk, rst,
    s1_valid && !advance, s1_valid && $stable(s1_item))

endmodule

[tb/sv/tb.sv]
// Testbench for session_mode_controller: directed and random words checked against
// an in-bench model of the session state. Depends on smc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb;
  import smc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  kind;
  logic [31:0] time_ms;
  logic [11:0] hr_value;
  logic        hr_valid;
  logic signed [1:0] still_flag;
  logic [11:0] impact_value;
  logic        impact_valid;
  logic [31:0] restore_tally;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  cue_type;
  logic [2:0]  current_mode;
  logic [31:0] tally_count;
  logic [8:0]  impact_rounded;
  logic        pacer_enabled;
  logic [11:0] pacer_first_ms;
  logic [12:0] pacer_second_ms;
  logic [1:0]  pacer_pattern;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Model of the session and the limits programmed into the block
  state_t  sess;
  cfg_t    limits;
  result_t reports_due[$];

  int          mismatches;
  int          holdoff_left;
  bit          quiet;
  logic [31:0] wall_ms;

  session_mode_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .time_ms(time_ms), .hr_value(hr_value), .hr_valid(hr_valid),
    .still_flag(still_flag), .impact_value(impact_value), .impact_valid(impact_valid),
    .restore_tally(restore_tally),
    .out_valid(out_valid), .out_ready(out_ready),
    .cue_type(cue_type), .current_mode(current_mode), .tally_count(tally_count),
    .impact_rounded(impact_rounded), .pacer_enabled(pacer_enabled),
    .pacer_first_ms(pacer_first_ms), .pacer_second_ms(pacer_second_ms),
    .pacer_pattern(pacer_pattern),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Switch mode in the model; a cue only when the mode really changes
  function automatic logic [2:0] enter_mode(logic [2:0] m, logic [31:0] t);
    if (sess.mode == m) return CUE_NONE;
    sess.mode = m;
    sess.entered_time = t;
    return CUE_MODE;
  endfunction

  // Apply one word to the model and return the result word it should produce
  function automatic result_t advance_session(item_t w);
    result_t     r;
    logic [31:0] elapsed;
    logic [12:0] rest_ceiling;
    logic [12:0] g_sum;
    logic        still;
    logic        calmed;
    r = '0;
    still = (w.still_flag == 2'b01);
    case (w.kind)
      KIND_START: begin
        sess.in_session = 1'b1;
        r.cue_type = enter_mode(MODE_TRANQUIL, w.time_ms);
      end
      KIND_END: begin
        sess.in_session = 1'b0;
        sess.mode = MODE_NONE;
        sess.entered_time = '0;
        r.cue_type = CUE_SUMMARY;
      end
      KIND_RESTORE: begin
        sess.in_session = 1'b1;
        sess.tally = w.restore_tally;
        sess.mode = MODE_NONE;
        r.cue_type = enter_mode(MODE_TRANQUIL, w.time_ms);
      end
      KIND_TICK: begin
        if (sess.in_session && sess.mode != MODE_NONE) begin
          elapsed = w.time_ms - sess.entered_time;
          // track the lowest still heart rate in the calm modes
          if ((sess.mode == MODE_TRANQUIL || sess.mode == MODE_SANCTUARY) &&
              w.hr_valid && still) begin
            if (!sess.resting_known || w.hr_value < sess.resting_rate) begin
              sess.resting_rate = w.hr_value;
            end
            sess.resting_known = 1'b1;
          end
          if (sess.mode == MODE_PRIME && elapsed >= limits.prime_timeout_ms) begin
            r.cue_type = enter_mode(MODE_TRANQUIL, w.time_ms);
          end else if (sess.mode == MODE_RECOVER) begin
            rest_ceiling = {1'b0, sess.resting_rate} + {1'b0, limits.recovered_margin};
            calmed = sess.resting_known && w.hr_valid && ({1'b0, w.hr_value} <= rest_ceiling);
            if (calmed || elapsed >= limits.recover_timeout_ms) begin
              r.cue_type = enter_mode(MODE_TRANQUIL, w.time_ms);
            end
          end
          // impact cue, whole g rounded half to even
          if (sess.mode == MODE_SUSTAIN && w.impact_valid &&
              w.impact_value >= limits.impact_threshold) begin
            r.cue_type = CUE_IMPACT;
            g_sum = {1'b0, w.impact_value} + 13'd7 + w.impact_value[4];
            r.impact_rounded = g_sum[12:4];
          end
        end
      end
      default: begin
        if (sess.in_session) begin
          case (w.kind)
            KIND_SANCTUARY:   r.cue_type = enter_mode(MODE_SANCTUARY, w.time_ms);
            KIND_PRIME:       r.cue_type = enter_mode(MODE_PRIME, w.time_ms);
            KIND_ROUND_START: r.cue_type = enter_mode(MODE_SUSTAIN, w.time_ms);
            KIND_ROUND_END:   r.cue_type = enter_mode(MODE_RECOVER, w.time_ms);
            KIND_TALLY: begin
              sess.tally = sess.tally + 32'd1;
              r.cue_type = CUE_TALLY;
            end
            default: ;
          endcase
        end
      end
    endcase
    // pacer settings follow the mode after the step
    case (sess.mode)
      MODE_SANCTUARY, MODE_TRANQUIL: begin
        r.pacer_enabled = 1'b1;
        r.pacer_first_ms = CALM_FIRST_MS;
        r.pacer_second_ms = CALM_SECOND_MS;
        r.pacer_pattern = PACER_RESONANCE;
      end
      MODE_PRIME: begin
        r.pacer_enabled = 1'b1;
        r.pacer_first_ms = PRIME_FIRST_MS;
        r.pacer_second_ms = PRIME_SECOND_MS;
        r.pacer_pattern = PACER_PRIME;
      end
      MODE_RECOVER: begin
        r.pacer_enabled = 1'b1;
        r.pacer_first_ms = RECOV_FIRST_MS;
        r.pacer_second_ms = RECOV_SECOND_MS;
        r.pacer_pattern = PACER_SIGH;
      end
      default: r.pacer_pattern = PACER_OFF;
    endcase
    r.current_mode = sess.mode;
    r.tally_count = sess.tally;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: cue %0d mode %0d", cue_type, current_mode);
        end
      end else begin
        want = reports_due.pop_front();
        check_field("cue_type", want.cue_type, cue_type);
        check_field("current_mode", want.current_mode, current_mode);
        check_field("tally_count", want.tally_count, tally_count);
        check_field("impact_rounded", want.impact_rounded, impact_rounded);
        check_field("pacer_enabled", want.pacer_enabled, pacer_enabled);
        check_field("pacer_first_ms", want.pacer_first_ms, pacer_first_ms);
        check_field("pacer_second_ms", want.pacer_second_ms, pacer_second_ms);
        check_field("pacer_pattern", want.pacer_pattern, pacer_pattern);
      end
    end
  end

  // Drive result ready: forced hold-off first, then quiet or random stalls
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_ready <= 1'b0;
      holdoff_left--;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 37);
    end
  end

  // Offer one word, with random gaps ahead of it, and log its prediction on acceptance
  task automatic send_word(input item_t w);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= w.kind;
    time_ms       <= w.time_ms;
    hr_value      <= w.hr_value;
    hr_valid      <= w.hr_valid;
    still_flag    <= w.still_flag;
    impact_value  <= w.impact_value;
    impact_valid  <= w.impact_valid;
    restore_tally <= w.restore_tally;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reports_due.push_back(advance_session(w));
  endtask

  task automatic send_tick(input logic [31:0] t, input logic [11:0] hr, input logic hr_ok,
                           input logic [1:0] still, input logic [11:0] imp,
                           input logic imp_ok);
    item_t w;
    w = '0;
    w.kind = KIND_TICK;
    w.time_ms = t;
    w.hr_value = hr;
    w.hr_valid = hr_ok;
    w.still_flag = still;
    w.impact_value = imp;
    w.impact_valid = imp_ok;
    send_word(w);
  endtask

  task automatic send_event(input logic [3:0] k, input logic [31:0] t,
                            input logic [31:0] tally);
    item_t w;
    w = '0;
    w.kind = k;
    w.time_ms = t;
    w.restore_tally = tally;
    send_word(w);
  endtask

  // Hold input idle until every predicted word has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PRIME_TIMEOUT:    limits.prime_timeout_ms = value;
      REG_RECOVER_TIMEOUT:  limits.recover_timeout_ms = value;
      REG_RECOVERED_MARGIN: limits.recovered_margin = value[11:0];
      REG_IMPACT_THRESHOLD: limits.impact_threshold = value[11:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(input logic [31:0] prime_ms, input logic [31:0] recover_ms,
                                input logic [11:0] margin, input logic [11:0] threshold);
    write_reg(REG_PRIME_TIMEOUT, prime_ms);
    write_reg(REG_RECOVER_TIMEOUT, recover_ms);
    write_reg(REG_RECOVERED_MARGIN, {20'd0, margin});
    write_reg(REG_IMPACT_THRESHOLD, {20'd0, threshold});
  endtask

  // Random word shaped like a live session: mostly ticks and mode events
  task automatic random_word(output item_t w);
    int pick;
    w = '0;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) begin
      wall_ms = $urandom();
    end else begin
      wall_ms = wall_ms + $urandom_range(0, 700);
    end
    w.time_ms = wall_ms;
    if (pick < 45)      w.kind = KIND_TICK;
    else if (pick < 52) w.kind = KIND_SANCTUARY;
    else if (pick < 60) w.kind = KIND_PRIME;
    else if (pick < 72) w.kind = KIND_ROUND_START;
    else if (pick < 80) w.kind = KIND_ROUND_END;
    else if (pick < 87) w.kind = KIND_TALLY;
    else if (pick < 92) w.kind = KIND_START;
    else if (pick < 95) w.kind = KIND_END;
    else if (pick < 98) w.kind = KIND_RESTORE;
    else                w.kind = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 2) != 0) begin
      w.hr_value = sess.resting_rate + 12'($urandom_range(0, 300));
    end else begin
      w.hr_value = 12'($urandom_range(0, 4095));
    end
    w.hr_valid = ($urandom_range(0, 9) < 8);
    case ($urandom_range(0, 4))
      0:       w.still_flag = 2'b00;
      1:       w.still_flag = 2'b11;
      default: w.still_flag = 2'b01;
    endcase
    w.impact_value = 12'($urandom_range(0, 4095));
    w.impact_valid = ($urandom_range(0, 9) < 7);
    case ($urandom_range(0, 3))
      0:       w.restore_tally = 32'hFFFF_FFFF - $urandom_range(0, 3);
      1:       w.restore_tally = $urandom_range(0, 20);
      default: w.restore_tally = $urandom();
    endcase
  endtask

  task automatic run_random(input int count);
    item_t w;
    repeat (count) begin
      random_word(w);
      send_word(w);
    end
  endtask

  // Reset-value limits: every event kind, edge timings and impact rounding
  task automatic test_directed_cases();
    logic [31:0] t;
    send_tick(32'd0, 12'd0, 1'b0, 2'b00, 12'd0, 1'b0);
    send_event(KIND_SANCTUARY, 32'd10, 32'd0);
    send_event(4'd15, 32'd20, 32'd0);
    send_event(KIND_START, 32'd1000, 32'd0);
    send_event(KIND_START, 32'd1100, 32'd0);
    send_tick(32'd1200, 12'd1000, 1'b1, 2'b01, 12'd0, 1'b0);
    send_tick(32'd1300, 12'd500, 1'b1, 2'b11, 12'd0, 1'b0);
    send_tick(32'd1400, 12'd400, 1'b0, 2'b01, 12'd0, 1'b0);
    send_event(KIND_SANCTUARY, 32'd2000, 32'd0);
    send_tick(32'd2100, 12'd960, 1'b1, 2'b01, 12'd0, 1'b0);
    // prime across the time wrap, one ms short and then exactly at the timeout
    t = 32'hFFFF_F000;
    send_event(KIND_PRIME, t, 32'd0);
    send_tick(t + 32'd59999, 12'hFFF, 1'b1, 2'b01, 12'hFFF, 1'b1);
    send_tick(t + 32'd60000, 12'd0, 1'b0, 2'b00, 12'd0, 1'b0);
    // impacts in sustain: at threshold, maximum, ties both ways
    send_event(KIND_ROUND_START, 32'd5000, 32'd0);
    send_tick(32'd5100, 12'd0, 1'b0, 2'b00, 12'd128, 1'b1);
    send_tick(32'd5200, 12'd0, 1'b0, 2'b00, 12'd127, 1'b1);
    send_tick(32'd5300, 12'd0, 1'b0, 2'b00, 12'hFFF, 1'b1);
    send_tick(32'd5400, 12'd0, 1'b0, 2'b00, 12'h188, 1'b1);
    send_tick(32'd5500, 12'd0, 1'b0, 2'b00, 12'h198, 1'b1);
    // recover ends on heart rate at the margin, then on the timeout
    send_event(KIND_ROUND_END, 32'd6000, 32'd0);
    send_tick(32'd6100, 12'd1120, 1'b1, 2'b00, 12'd0, 1'b0);
    send_event(KIND_ROUND_END, 32'd7000, 32'd0);
    send_tick(32'd7000 + 32'd119999, 12'd1121, 1'b1, 2'b00, 12'd0, 1'b0);
    send_tick(32'd7000 + 32'd120000, 12'd1121, 1'b1, 2'b00, 12'd0, 1'b0);
    // restore with tally about to wrap, then wrap it, then close the session
    send_event(KIND_RESTORE, 32'd9000, 32'hFFFF_FFFF);
    send_event(KIND_TALLY, 32'd9100, 32'd0);
    send_event(KIND_END, 32'd9200, 32'd0);
    send_tick(32'd9300, 12'd100, 1'b1, 2'b01, 12'd0, 1'b0);
    drain();
  endtask

  // Limits at their extremes: zero timeouts and margins, then all ones
  task automatic test_limit_extremes();
    program_limits(32'd0, 32'd0, 12'd0, 12'd0);
    run_random(150);
    drain();
    program_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
    run_random(150);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    program_limits(32'd1500, 32'd2500, 12'd80, 12'd1000);
    @(posedge clk);
    holdoff_left = 80;
    quiet = 1'b1;
    run_random(40);
    quiet = 1'b0;
    drain();
  endtask

  // Random sessions under several random limit settings, one phase without stalls
  task automatic test_random_sessions();
    for (int phase = 0; phase < 4; phase++) begin
      program_limits($urandom_range(0, 3000), $urandom_range(0, 6000),
                     12'($urandom_range(0, 400)), 12'($urandom_range(0, 4095)));
      quiet = (phase == 2);
      run_random(400);
      quiet = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    time_ms = '0;
    hr_value = '0;
    hr_valid = 1'b0;
    still_flag = '0;
    impact_value = '0;
    impact_valid = 1'b0;
    restore_tally = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    holdoff_left = 0;
    quiet = 1'b0;
    wall_ms = '0;
    sess = '0;
    limits = '{PRIME_TIMEOUT_RST, RECOVER_TIMEOUT_RST,
               RECOVERED_MARGIN_RST, IMPACT_THRESHOLD_RST};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_limit_extremes();
    test_output_stall();
    test_random_sessions();

    // let any stray word show up before the verdict
    repeat (10) @(posedge clk);
    if (reports_due.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/smc_pkg.sv
rtl/smc_step.sv
rtl/session_mode_controller.sv
tb/sv/tb.sv
